// ===== hdl/lir_pkg.sv =====
// Package for the linear interpolation resampler.
// Holds shared widths, constants, the controller state type and the command/status structs.
// No dependencies.
`default_nettype none

package lir_pkg;

    localparam int LIR_FRAC_BITS = 16;
    localparam int SAMPLE_W = 16;
    localparam int STEP_W = 20;
    localparam int CNT_W = 3;

    localparam logic [STEP_W-1:0] STEP_RESET = 20'd196608;
    localparam logic [CNT_W-1:0] LOOP_MAX = 3'd4;
    localparam logic [SAMPLE_W-1:0] SAT_MAX = 16'h7FFF;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PICK,
        ST_MUL,
        ST_RND,
        ST_FIN
    } lir_state_t;

    typedef struct packed {
        logic load_in;
        logic issue;
        logic sel_self;
        logic load_out;
        logic commit;
    } lir_cmd_t;

    typedef struct packed {
        logic have_prev;
        logic in_last;
        logic loop_go;
        logic tail_hit;
        logic out_free;
    } lir_stat_t;

endpackage

`default_nettype wire

// ===== hdl/lir_ctrl.sv =====
// Controller state machine of the linear interpolation resampler.
// Sequences input transfer, per-output interpolation and stream state update.
// Depends on lir_pkg.
`default_nettype none

module lir_ctrl
    import lir_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire lir_stat_t stat,
    output lir_cmd_t       cmd
);

    lir_state_t state_reg;
    lir_state_t state_next;
    logic       fin_reg;
    logic       fin_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            fin_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            fin_reg   <= fin_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        fin_next   = fin_reg;
        unique case (state_reg)
            ST_IDLE: begin
                fin_next = 1'b0;
                if (s_valid) begin
                    state_next = ST_PICK;
                end
            end
            ST_PICK: begin
                fin_next = !stat.have_prev || !stat.loop_go;
                if (!stat.have_prev) begin
                    state_next = stat.in_last ? ST_MUL : ST_FIN;
                end else if (stat.loop_go || stat.tail_hit) begin
                    state_next = ST_MUL;
                end else begin
                    state_next = ST_FIN;
                end
            end
            ST_MUL: begin
                state_next = ST_RND;
            end
            ST_RND: begin
                if (stat.out_free) begin
                    state_next = fin_reg ? ST_FIN : ST_PICK;
                end
            end
            ST_FIN: begin
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.load_in = s_valid;
            end
            ST_PICK: begin
                cmd.sel_self = !stat.have_prev || !stat.loop_go;
                if (!stat.have_prev) begin
                    cmd.issue = stat.in_last;
                end else begin
                    cmd.issue = stat.loop_go || stat.tail_hit;
                end
            end
            ST_MUL: begin
                cmd = '0;
            end
            ST_RND: begin
                cmd.load_out = stat.out_free;
            end
            ST_FIN: begin
                cmd.commit = 1'b1;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/lir_dp.sv =====
// Datapath of the linear interpolation resampler.
// Holds the step register, stream state, interpolation multiplier, rescale/round stage
// and the output register. Depends on lir_pkg.
`default_nettype none

module lir_dp
    import lir_pkg::*;
#(
    parameter int FRAC_BITS = LIR_FRAC_BITS
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       cfg_we,
    input  wire logic [STEP_W-1:0]          cfg_wdata,
    input  wire logic signed [SAMPLE_W-1:0] s_in_sample,
    input  wire logic                       s_in_last,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic signed [SAMPLE_W-1:0]      m_out_sample,
    output logic                            m_run_last,
    output logic                            m_stream_end,
    input  wire lir_cmd_t                   cmd,
    output lir_stat_t                       stat
);

    localparam int OFFS_W = ((FRAC_BITS > STEP_W) ? FRAC_BITS : STEP_W) + 1;
    localparam int NUM_W = FRAC_BITS + SAMPLE_W + 2;
    localparam int MAG_W = NUM_W - 1;
    localparam int SCL_W = MAG_W + 15;
    localparam int Q_W = SCL_W - (15 + FRAC_BITS);
    localparam logic [OFFS_W-1:0] ONE_POS = OFFS_W'(1) << FRAC_BITS;
    localparam logic [OFFS_W-1:0] MIN_STEP = OFFS_W'(1) << (FRAC_BITS - 2);
    localparam logic [SCL_W-1:0] RND_HALF = SCL_W'(1) << (14 + FRAC_BITS);

    logic [STEP_W-1:0]          step_reg;
    logic signed [SAMPLE_W-1:0] prev_reg;
    logic                       have_prev_reg;
    logic [OFFS_W-1:0]          offset_reg;
    logic signed [SAMPLE_W-1:0] x_reg;
    logic                       last_reg;
    logic [CNT_W-1:0]           cnt_reg;

    logic signed [SAMPLE_W-1:0] op_a_reg;
    logic signed [SAMPLE_W-1:0] op_b_reg;
    logic [FRAC_BITS-1:0]       op_frac_reg;
    logic                       op_rl_reg;
    logic                       op_se_reg;
    logic signed [NUM_W-1:0]    num_reg;

    logic signed [SAMPLE_W-1:0] m_sample_reg;
    logic                       m_run_last_reg;
    logic                       m_stream_end_reg;
    logic                       m_valid_reg;

    logic [OFFS_W-1:0]          step_eff;
    logic [OFFS_W-1:0]          offset_sum;
    logic [CNT_W-1:0]           cnt_inc;
    logic                       more_loop;
    logic                       tail_after;
    logic                       rl_loop;

    logic signed [SAMPLE_W:0]   diff;
    logic signed [NUM_W-1:0]    base_term;
    logic signed [NUM_W-1:0]    mult_term;
    logic signed [NUM_W-1:0]    num_next;

    logic                       num_neg;
    logic [MAG_W-1:0]           mag;
    logic [SCL_W-1:0]           scaled;
    logic [Q_W-1:0]             q_full;
    logic [SAMPLE_W-1:0]        q_sat;
    logic [SAMPLE_W-1:0]        res;

    assign step_eff   = (OFFS_W'(step_reg) < MIN_STEP) ? MIN_STEP : OFFS_W'(step_reg);
    assign offset_sum = offset_reg + step_eff;
    assign cnt_inc    = cnt_reg + CNT_W'(1);
    assign more_loop  = (offset_sum < ONE_POS) && (cnt_inc < LOOP_MAX);
    assign tail_after = last_reg && (offset_sum == ONE_POS);
    assign rl_loop    = !more_loop && !tail_after;

    assign stat.have_prev = have_prev_reg;
    assign stat.in_last   = last_reg;
    assign stat.loop_go   = (offset_reg < ONE_POS) && (cnt_reg < LOOP_MAX);
    assign stat.tail_hit  = last_reg && (offset_reg == ONE_POS);
    assign stat.out_free  = !m_valid_reg || m_ready;

    assign diff      = {op_b_reg[SAMPLE_W-1], op_b_reg} - {op_a_reg[SAMPLE_W-1], op_a_reg};
    assign base_term = {{(NUM_W - SAMPLE_W - FRAC_BITS){op_a_reg[SAMPLE_W-1]}}, op_a_reg,
                        {FRAC_BITS{1'b0}}};
    assign mult_term = NUM_W'($signed({1'b0, op_frac_reg})) * NUM_W'(diff);
    assign num_next  = base_term + mult_term;

    assign num_neg = num_reg[NUM_W-1];
    assign mag     = num_neg ? MAG_W'(-num_reg) : MAG_W'(num_reg);
    assign scaled  = (SCL_W'(mag) << 15) - SCL_W'(mag) + RND_HALF;
    assign q_full  = scaled[SCL_W-1:15+FRAC_BITS];
    assign q_sat   = (q_full > Q_W'(SAT_MAX)) ? SAT_MAX : q_full[SAMPLE_W-1:0];
    assign res     = num_neg ? -q_sat : q_sat;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg      <= STEP_RESET;
            prev_reg      <= '0;
            have_prev_reg <= 1'b0;
            offset_reg    <= '0;
            cnt_reg       <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_we) begin
                step_reg <= cfg_wdata;
            end
            if (cmd.load_in) begin
                cnt_reg <= '0;
            end
            if (cmd.issue && !cmd.sel_self) begin
                offset_reg <= offset_sum;
                cnt_reg    <= cnt_inc;
            end
            if (cmd.commit) begin
                prev_reg <= x_reg;
                if (last_reg) begin
                    have_prev_reg <= 1'b0;
                    offset_reg    <= '0;
                end else if (!have_prev_reg) begin
                    have_prev_reg <= 1'b1;
                    offset_reg    <= '0;
                end else begin
                    offset_reg <= offset_reg - ONE_POS;
                end
            end
            if (cmd.load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            x_reg    <= s_in_sample;
            last_reg <= s_in_last;
        end
        if (cmd.issue) begin
            op_b_reg <= x_reg;
            if (cmd.sel_self) begin
                op_a_reg    <= x_reg;
                op_frac_reg <= '0;
                op_rl_reg   <= 1'b1;
                op_se_reg   <= last_reg;
            end else begin
                op_a_reg    <= prev_reg;
                op_frac_reg <= offset_reg[FRAC_BITS-1:0];
                op_rl_reg   <= rl_loop;
                op_se_reg   <= rl_loop && last_reg;
            end
        end
        num_reg <= num_next;
        if (cmd.load_out) begin
            m_sample_reg     <= res;
            m_run_last_reg   <= op_rl_reg;
            m_stream_end_reg <= op_se_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_out_sample = m_sample_reg;
    assign m_run_last   = m_run_last_reg;
    assign m_stream_end = m_stream_end_reg;

endmodule

`default_nettype wire

// ===== hdl/linear_interp_resampler.sv =====
// Top level of the linear interpolation resampler: controller plus datapath.
// Depends on lir_pkg, lir_ctrl and lir_dp.
//
// Usage: input samples arrive on the s_ channel (s_in_sample, s_in_last) and
// interpolated 16 kHz samples leave on the m_ channel (m_out_sample, m_run_last,
// m_stream_end), both with valid/ready transfers. The phase step register is
// written through cfg_we/cfg_wdata; the user must write it only while the block
// is idle, as the block itself does not enforce this. One input item is handled
// at a time by a controller that visits a shared multiplier and a rescale/round
// stage once per output. An item produces up to five outputs; the controller
// passes through ST_PICK, ST_MUL and ST_RND for each output and through ST_FIN
// once per item. The first output passes through the operand registers, num_reg
// and the output register before it appears on m_valid.
// A finished output waits in the output register; the controller moves on to
// the next output or accepts the next item, and only stalls when it has a new
// result and the output register is still occupied.
// After reset the step is 196608 (3.0 at 16 fraction bits) and the stream
// state is empty; after an item marked last the stream state restarts.
`default_nettype none

module linear_interp_resampler
    import lir_pkg::*;
#(
    parameter int FRAC_BITS = LIR_FRAC_BITS
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       cfg_we,
    input  wire logic [STEP_W-1:0]          cfg_wdata,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic signed [SAMPLE_W-1:0] s_in_sample,
    input  wire logic                       s_in_last,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic signed [SAMPLE_W-1:0]      m_out_sample,
    output logic                            m_run_last,
    output logic                            m_stream_end
);

    lir_cmd_t  cmd;
    lir_stat_t stat;

    lir_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    lir_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .s_in_sample  (s_in_sample),
        .s_in_last    (s_in_last),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_sample (m_out_sample),
        .m_run_last   (m_run_last),
        .m_stream_end (m_stream_end),
        .cmd          (cmd),
        .stat         (stat)
    );

endmodule

`default_nettype wire

// ===== tb/linear_interp_resampler_tb.sv =====
// Self-checking testbench for linear_interp_resampler: drives sample streams and step settings,
// predicts every 16 kHz output from its own interpolation model, and checks each transfer.
// Depends on lir_pkg and the linear_interp_resampler RTL.
`timescale 1ns / 100ps

module linear_interp_resampler_tb
    import lir_pkg::*;
();

    localparam int FRAC = LIR_FRAC_BITS;
    localparam longint ONE_POS = 64'sd1 << FRAC;
    localparam longint MIN_STEP = ONE_POS >>> 2;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE_CYCLES = 8;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] smp;
        logic run_last;
        logic stream_end;
    } resampled_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [STEP_W-1:0] cfg_wdata = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [SAMPLE_W-1:0] s_in_sample = '0;
    logic s_in_last = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [SAMPLE_W-1:0] m_out_sample;
    logic m_run_last;
    logic m_stream_end;

    // Interpolator state as the block should hold it.
    logic [STEP_W-1:0] step_setting = STEP_RESET;
    logic signed [SAMPLE_W-1:0] held_sample = '0;
    bit primed = 1'b0;
    longint unsigned phase_acc = 0;

    resampled_t expected_q[$];
    int error_count = 0;
    int src_idle_pct = 0;
    int snk_idle_pct = 0;
    int hold_reqs = 0;
    int hold_served = 0;
    int hold_left = 0;

    linear_interp_resampler u_top (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_in_sample(s_in_sample),
        .s_in_last(s_in_last),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_out_sample(m_out_sample),
        .m_run_last(m_run_last),
        .m_stream_end(m_stream_end)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    initial begin
        #10_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Interpolates a..b at frac, rescales by 32767/32768, rounds half away from zero.
    function automatic logic signed [SAMPLE_W-1:0] blend_rescale(
        input logic signed [SAMPLE_W-1:0] a,
        input logic signed [SAMPLE_W-1:0] b,
        input longint unsigned frac
    );
        longint num;
        longint unsigned mag;
        longint unsigned q;
        bit neg;
        num = longint'(a) * ONE_POS + longint'(frac) * (longint'(b) - longint'(a));
        neg = num < 0;
        mag = neg ? longint'(-num) : longint'(num);
        mag = mag * 32767;
        q = (mag + (64'd1 << (14 + FRAC))) >> (15 + FRAC);
        if (q > 32767)
            q = 32767;
        return neg ? -$signed(q[SAMPLE_W-1:0]) : $signed(q[SAMPLE_W-1:0]);
    endfunction

    task automatic resample_item(input logic signed [SAMPLE_W-1:0] x, input logic last);
        resampled_t outs[5];
        int n;
        longint unsigned stp;
        n = 0;
        stp = (longint'(step_setting) < MIN_STEP) ? MIN_STEP : longint'(step_setting);
        if (!primed) begin
            primed = 1'b1;
            phase_acc = 0;
            if (last) begin
                outs[n] = '{smp: blend_rescale(x, x, 0), run_last: 1'b0, stream_end: 1'b0};
                n++;
            end
        end else begin
            while (phase_acc < ONE_POS && n < 4) begin
                outs[n] = '{smp: blend_rescale(held_sample, x, phase_acc), run_last: 1'b0,
                            stream_end: 1'b0};
                n++;
                phase_acc += stp;
            end
            phase_acc -= ONE_POS;
            if (last && phase_acc == 0) begin
                outs[n] = '{smp: blend_rescale(x, x, 0), run_last: 1'b0, stream_end: 1'b0};
                n++;
            end
        end
        held_sample = x;
        if (n > 0) begin
            outs[n-1].run_last = 1'b1;
            outs[n-1].stream_end = last;
        end
        if (last) begin
            held_sample = '0;
            primed = 1'b0;
            phase_acc = 0;
        end
        for (int i = 0; i < n; i++)
            expected_q = {expected_q, outs[i]};
    endtask

    always @(posedge aclk) begin
        if (hold_left != 0) begin
            m_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_reqs != hold_served) begin
            m_ready <= 1'b0;
            hold_served <= hold_served + 1;
            hold_left <= HOLD_CYCLES;
        end else begin
            m_ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    always @(posedge aclk) begin
        resampled_t exp_r;
        if (aresetn && m_valid && m_ready) begin
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected transfer, got sample %0d run_last %0b stream_end %0b",
                         $time, m_out_sample, m_run_last, m_stream_end);
                error_count++;
            end else begin
                exp_r = expected_q.pop_front();
                if (m_out_sample !== exp_r.smp) begin
                    $display("%0t: out_sample expected %0d, got %0d",
                             $time, exp_r.smp, m_out_sample);
                    error_count++;
                end
                if (m_run_last !== exp_r.run_last) begin
                    $display("%0t: run_last expected %0b, got %0b",
                             $time, exp_r.run_last, m_run_last);
                    error_count++;
                end
                if (m_stream_end !== exp_r.stream_end) begin
                    $display("%0t: stream_end expected %0b, got %0b",
                             $time, exp_r.stream_end, m_stream_end);
                    error_count++;
                end
            end
        end
    end

    task automatic send_sample(input logic signed [SAMPLE_W-1:0] smp, input logic last);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_in_sample <= smp;
        s_in_last <= last;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        resample_item(smp, last);
    endtask

    // Stops the sender and waits until the block has nothing left in flight.
    task automatic wait_drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_q.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_step(input logic [STEP_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        step_setting = value;
    endtask

    function automatic logic signed [SAMPLE_W-1:0] random_sample();
        case ($urandom_range(7))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return $signed(16'($urandom_range(16))) - 16'sd8;
            default: return $signed(16'($urandom));
        endcase
    endfunction

    function automatic logic [STEP_W-1:0] pick_step();
        case ($urandom_range(9))
            0: return STEP_W'($urandom_range(0, 16383));
            1: return STEP_W'($urandom_range(786433, 1048575));
            2: return STEP_W'($urandom_range(16384, 65536));
            default: return STEP_W'($urandom_range(16384, 786432));
        endcase
    endfunction

    task automatic test_reset_step();
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sh7FFF, 1'b0);
        send_sample(16'sh0000, 1'b0);
        send_sample(-16'sd1, 1'b0);
        send_sample(16'sd1, 1'b0);
        send_sample(16'sh5555, 1'b1);
        send_sample(16'sh7FFF, 1'b1);
        send_sample(16'sh8000, 1'b1);
    endtask

    task automatic test_step_extremes();
        wait_drain();
        write_step('0);
        send_sample(16'sd100, 1'b0);
        send_sample(-16'sd100, 1'b0);
        send_sample(16'sh7FFF, 1'b1);
        wait_drain();
        write_step('1);
        send_sample(16'sh1234, 1'b0);
        send_sample(-16'sd2000, 1'b0);
        send_sample(16'sd300, 1'b1);
        wait_drain();
        write_step(STEP_W'(786432));
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sh7FFF, 1'b1);
        wait_drain();
        write_step(STEP_W'(65536));
        send_sample(16'sh2AAA, 1'b0);
        send_sample(-16'sh2AAB, 1'b0);
        send_sample(16'sd7, 1'b1);
    endtask

    // The stream stays open across the pause; the new step applies to the phase increments after the next position.
    task automatic test_midstream_step();
        send_sample(16'sd1000, 1'b0);
        send_sample(-16'sd1000, 1'b0);
        send_sample(16'sd5000, 1'b0);
        wait_drain();
        write_step(STEP_W'(32768));
        send_sample(-16'sd5000, 1'b0);
        send_sample(16'sh7FFF, 1'b0);
        send_sample(16'sh8000, 1'b1);
    endtask

    task automatic test_backpressure();
        wait_drain();
        write_step(STEP_W'(16384));
        hold_reqs++;
        for (int i = 0; i < 24; i++)
            send_sample(random_sample(), i == 23);
        wait_drain();
    endtask

    task automatic test_random_phase(input int src_pct, input int snk_pct, input int n_items);
        int sent;
        int len;
        sent = 0;
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        wait_drain();
        write_step(pick_step());
        while (sent < n_items) begin
            len = $urandom_range(1, 40);
            for (int i = 0; i < len; i++) begin
                if (i == len / 2 && i != 0 && $urandom_range(7) == 0) begin
                    wait_drain();
                    write_step(pick_step());
                end
                send_sample(random_sample(), i == len - 1);
                sent++;
            end
            if ($urandom_range(3) == 0) begin
                wait_drain();
                write_step(pick_step());
            end
        end
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        src_idle_pct = 12;
        snk_idle_pct = 67;
        test_reset_step();
        test_step_extremes();
        test_midstream_step();
        test_backpressure();
        test_random_phase(12, 67, 110);
        test_random_phase(67, 12, 110);
        test_random_phase(0, 0, 110);
        wait_drain();
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
